@@ hdl/dtq_pkg.sv @@
// Shared constants, types and helpers for the deadline timer queue.
package dtq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TIME_BITS   = 32;
    localparam int TAG_BITS    = 8;
    localparam int DELAY_BITS  = 16;
    localparam int KIND_BITS   = 2;
    localparam int PEND_BITS   = 5;
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
    // second queue slot, used for look-ahead on the next due job
    localparam int NEXT_IDX    = (QUEUE_DEPTH > 1) ? 1 : 0;

    localparam logic CMD_SCHEDULE = 1'b0;
    localparam logic CMD_TICK     = 1'b1;

    localparam logic [KIND_BITS-1:0] KIND_FIRED    = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_ACCEPTED = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_REJECTED = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_IDLE     = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DUE,
        ST_CMP,
        ST_INS,
        ST_REJ,
        ST_ADV,
        ST_CHK
    } dtq_state_t;

    typedef struct packed {
        logic load;
        logic calc_due;
        logic compare;
        logic insert;
        logic reject;
        logic adv_time;
        logic pop;
        logic idle_tick;
    } dtq_cmd_t;

    typedef struct packed {
        logic full;
        logic head_due;
        logic more_due;
        logic out_free;
    } dtq_status_t;

    // a strictly before b, wrap-safe
    function automatic logic time_before(input logic [TIME_BITS-1:0] a,
                                         input logic [TIME_BITS-1:0] b);
        logic [TIME_BITS-1:0] diff;
        diff = a - b;
        return diff[TIME_BITS-1];
    endfunction

endpackage

@@ hdl/dtq_if.sv @@
// Request and result channel interfaces.
interface dtq_in_if;
    logic                           valid;
    logic                           ready;
    logic                           command;
    logic [dtq_pkg::TAG_BITS-1:0]   job_tag;
    logic [dtq_pkg::DELAY_BITS-1:0] delay;

    modport source (output valid, output command, output job_tag, output delay,
                    input ready);
    modport sink (input valid, input command, input job_tag, input delay,
                  output ready);
endinterface

interface dtq_out_if;
    logic                          valid;
    logic                          ready;
    logic [dtq_pkg::KIND_BITS-1:0] kind;
    logic [dtq_pkg::TAG_BITS-1:0]  fired_tag;
    logic [dtq_pkg::PEND_BITS-1:0] pending;
    logic                          last;

    modport source (output valid, output kind, output fired_tag, output pending,
                    output last, input ready);
    modport sink (input valid, input kind, input fired_tag, input pending,
                  input last, output ready);
endinterface

@@ hdl/dtq_ctrl.sv @@
// Sequencing state machine for schedule and tick commands.
module dtq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_command,
    output logic                 in_ready,
    input  dtq_pkg::dtq_status_t status,
    output dtq_pkg::dtq_cmd_t    cmd
);

    dtq_pkg::dtq_state_t state_reg;
    dtq_pkg::dtq_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dtq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dtq_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_command == dtq_pkg::CMD_TICK)
                    begin
                        state_next = dtq_pkg::ST_ADV;
                    end
                    else if (status.full)
                    begin
                        state_next = dtq_pkg::ST_REJ;
                    end
                    else
                    begin
                        state_next = dtq_pkg::ST_DUE;
                    end
                end
            end
            dtq_pkg::ST_DUE: state_next = dtq_pkg::ST_CMP;
            dtq_pkg::ST_CMP: state_next = dtq_pkg::ST_INS;
            dtq_pkg::ST_INS,
            dtq_pkg::ST_REJ:
            begin
                if (status.out_free)
                begin
                    state_next = dtq_pkg::ST_IDLE;
                end
            end
            dtq_pkg::ST_ADV: state_next = dtq_pkg::ST_CHK;
            dtq_pkg::ST_CHK:
            begin
                // leave once the final result of the tick is written
                if (status.out_free && (!status.head_due || !status.more_due))
                begin
                    state_next = dtq_pkg::ST_IDLE;
                end
            end
            default: state_next = dtq_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            dtq_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            dtq_pkg::ST_DUE: cmd.calc_due = 1'b1;
            dtq_pkg::ST_CMP: cmd.compare  = 1'b1;
            dtq_pkg::ST_INS: cmd.insert   = status.out_free;
            dtq_pkg::ST_REJ: cmd.reject   = status.out_free;
            dtq_pkg::ST_ADV: cmd.adv_time = 1'b1;
            dtq_pkg::ST_CHK:
            begin
                cmd.pop       = status.out_free && status.head_due;
                cmd.idle_tick = status.out_free && !status.head_due;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // only one datapath action per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.calc_due, cmd.compare, cmd.insert, cmd.reject,
                  cmd.adv_time, cmd.pop, cmd.idle_tick}))
        else $error("dtq_ctrl: overlapping datapath commands");

    // a schedule is never inserted into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |-> !status.full)
        else $error("dtq_ctrl: insert while full");

    // a tick always advances time before checking the head
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dtq_pkg::ST_CHK && $past(state_reg) != dtq_pkg::ST_CHK)
            |-> $past(cmd.adv_time))
        else $error("dtq_ctrl: head check without time advance");

endmodule

@@ hdl/dtq_datapath.sv @@
// Sorted job queue, time counter and result register.
module dtq_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  dtq_pkg::dtq_cmd_t                cmd,
    output dtq_pkg::dtq_status_t             status,
    input  logic [dtq_pkg::TAG_BITS-1:0]     job_tag,
    input  logic [dtq_pkg::DELAY_BITS-1:0]   delay,
    dtq_out_if.source                        rsp
);

    localparam int Q = dtq_pkg::QUEUE_DEPTH;

    logic [dtq_pkg::TAG_BITS-1:0]   tag_reg;
    logic [dtq_pkg::DELAY_BITS-1:0] delay_reg;
    logic [dtq_pkg::TIME_BITS-1:0]  due_reg;
    logic [dtq_pkg::TIME_BITS-1:0]  time_reg;
    logic [dtq_pkg::CNT_BITS-1:0]   count_reg;
    logic [dtq_pkg::CNT_BITS-1:0]   count_next;
    logic [Q-1:0]                   hit_reg;
    logic [Q-1:0]                   hit_next;
    logic [Q-1:0]                   ge;
    logic [Q-1:0]                   ins_at;
    logic                           any_hit;

    logic [dtq_pkg::TIME_BITS-1:0]  dl_reg  [Q];
    logic [dtq_pkg::TIME_BITS-1:0]  dl_next [Q];
    logic [dtq_pkg::TAG_BITS-1:0]   tg_reg  [Q];
    logic [dtq_pkg::TAG_BITS-1:0]   tg_next [Q];

    logic                           out_valid_reg;
    logic [dtq_pkg::KIND_BITS-1:0]  out_kind_reg;
    logic [dtq_pkg::TAG_BITS-1:0]   out_tag_reg;
    logic [dtq_pkg::PEND_BITS-1:0]  out_pend_reg;
    logic                           out_last_reg;
    logic                           emit;

    // per-entry compare: new deadline strictly before stored one
    always_comb
    begin
        for (int i = 0; i < Q; i++)
        begin
            hit_next[i] = (dtq_pkg::CNT_BITS'(i) < count_reg)
                          && dtq_pkg::time_before(due_reg, dl_reg[i]);
        end
    end

    // ge marks the first hit and everything after it
    always_comb
    begin
        ge[0] = hit_reg[0];
        for (int i = 1; i < Q; i++)
        begin
            ge[i] = ge[i-1] | hit_reg[i];
        end
        any_hit   = ge[Q-1];
        ins_at[0] = ge[0] | (!any_hit && count_reg == '0);
        for (int i = 1; i < Q; i++)
        begin
            ins_at[i] = (ge[i] & ~ge[i-1])
                        | (!any_hit && dtq_pkg::CNT_BITS'(i) == count_reg);
        end
    end

    always_comb
    begin
        dl_next    = dl_reg;
        tg_next    = tg_reg;
        count_next = count_reg;
        if (cmd.insert)
        begin
            for (int i = 1; i < Q; i++)
            begin
                if (ge[i-1])
                begin
                    dl_next[i] = dl_reg[i-1];
                    tg_next[i] = tg_reg[i-1];
                end
            end
            for (int i = 0; i < Q; i++)
            begin
                if (ins_at[i])
                begin
                    dl_next[i] = due_reg;
                    tg_next[i] = tag_reg;
                end
            end
            count_next = count_reg + 1'b1;
        end
        else if (cmd.pop)
        begin
            for (int i = 0; i < Q - 1; i++)
            begin
                dl_next[i] = dl_reg[i+1];
                tg_next[i] = tg_reg[i+1];
            end
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        dl_reg <= dl_next;
        tg_reg <= tg_next;
        if (cmd.load)
        begin
            tag_reg   <= job_tag;
            delay_reg <= delay;
        end
        if (cmd.calc_due)
        begin
            due_reg <= time_reg + dtq_pkg::TIME_BITS'(delay_reg);
        end
        if (cmd.compare)
        begin
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.adv_time)
            begin
                time_reg <= time_reg + 1'b1;
            end
        end
    end

    assign status.full     = (count_reg == dtq_pkg::CNT_BITS'(Q));
    assign status.head_due = (count_reg != '0)
                             && dtq_pkg::time_before(dl_reg[0], time_reg);
    assign status.more_due = (count_reg > dtq_pkg::CNT_BITS'(1))
                             && dtq_pkg::time_before(dl_reg[dtq_pkg::NEXT_IDX], time_reg);
    assign status.out_free = !out_valid_reg || rsp.ready;

    assign emit = cmd.insert || cmd.reject || cmd.pop || cmd.idle_tick;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_pend_reg <= dtq_pkg::PEND_BITS'(count_next);
            if (cmd.insert)
            begin
                out_kind_reg <= dtq_pkg::KIND_ACCEPTED;
                out_tag_reg  <= tag_reg;
                out_last_reg <= 1'b1;
            end
            else if (cmd.pop)
            begin
                out_kind_reg <= dtq_pkg::KIND_FIRED;
                out_tag_reg  <= tg_reg[0];
                out_last_reg <= !status.more_due;
            end
            else if (cmd.reject)
            begin
                out_kind_reg <= dtq_pkg::KIND_REJECTED;
                out_tag_reg  <= '0;
                out_last_reg <= 1'b1;
            end
            else
            begin
                out_kind_reg <= dtq_pkg::KIND_IDLE;
                out_tag_reg  <= '0;
                out_last_reg <= 1'b1;
            end
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.kind      = out_kind_reg;
    assign rsp.fired_tag = out_tag_reg;
    assign rsp.pending   = out_pend_reg;
    assign rsp.last      = out_last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= dtq_pkg::CNT_BITS'(Q))
        else $error("dtq_datapath: queue count overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |=> count_reg == $past(count_reg) - 1'b1)
        else $error("dtq_datapath: pop did not decrement count");

    // a held result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |-> !emit)
        else $error("dtq_datapath: result overwritten while stalled");

endmodule

@@ hdl/deadline_timer_queue.sv @@
// Deadline timer queue top level: controller plus datapath.
// Schedule: the transfer is latched, then the deadline add, compare and insert steps produce the result.
// Tick: time advance, then head check; fired jobs leave the head one per cycle while the result register is free.
// One command is in flight at a time; a new one is taken while the last result waits.
// Reset clears time, job count and handshake state; queue entries are not cleared.
module deadline_timer_queue (
    input  logic      clk,
    input  logic      rst_n,
    dtq_in_if.sink    req,
    dtq_out_if.source rsp
);

    dtq_pkg::dtq_cmd_t    cmd;
    dtq_pkg::dtq_status_t status;
    logic                 in_ready;

    assign req.ready = in_ready;

    dtq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req.valid),
        .in_command (req.command),
        .in_ready   (in_ready),
        .status     (status),
        .cmd        (cmd)
    );

    dtq_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .status  (status),
        .job_tag (req.job_tag),
        .delay   (req.delay),
        .rsp     (rsp)
    );

endmodule

@@ bench/tb_top.sv @@
// Testbench for deadline_timer_queue: directed and random schedule/tick traffic, checked per result.
`timescale 1ns / 100ps

module tb_top;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_ITEMS = 115;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [dtq_pkg::KIND_BITS-1:0] kind;
        logic [dtq_pkg::TAG_BITS-1:0]  tag;
        logic [dtq_pkg::PEND_BITS-1:0] pending;
        logic                          last;
    } timer_result_t;

    logic clk = 1'b0;
    logic rst_n;

    dtq_in_if  req_ch ();
    dtq_out_if rsp_ch ();

    deadline_timer_queue DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // predicted timer state
    logic [dtq_pkg::TIME_BITS-1:0] clock_ms;
    logic [dtq_pkg::TIME_BITS-1:0] queued_due[$];
    logic [dtq_pkg::TAG_BITS-1:0]  queued_tag[$];
    timer_result_t                 awaited_results[$];

    int errors = 0;
    int burst_left = 0;
    int hold_request = 0;
    int idle_cycles = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // wrap-safe: a is strictly earlier than b
    function automatic logic earlier_than(input logic [dtq_pkg::TIME_BITS-1:0] a,
                                          input logic [dtq_pkg::TIME_BITS-1:0] b);
        logic [dtq_pkg::TIME_BITS-1:0] gap;
        gap = a - b;
        return gap[dtq_pkg::TIME_BITS-1];
    endfunction

    function automatic timer_result_t make_result(
        input logic [dtq_pkg::KIND_BITS-1:0] kind,
        input logic [dtq_pkg::TAG_BITS-1:0]  tag,
        input logic                          last);
        timer_result_t r;
        r.kind    = kind;
        r.tag     = tag;
        r.pending = dtq_pkg::PEND_BITS'(queued_due.size());
        r.last    = last;
        return r;
    endfunction

    task automatic append_result(input timer_result_t r);
        awaited_results.insert(awaited_results.size(), r);
    endtask

    task automatic schedule_or_tick(input logic cmd,
                                    input logic [dtq_pkg::TAG_BITS-1:0] tag,
                                    input logic [dtq_pkg::DELAY_BITS-1:0] dly);
        logic [dtq_pkg::TIME_BITS-1:0] due;
        int slot;
        int fired;
        logic [dtq_pkg::TAG_BITS-1:0] head_tag;
        timer_result_t tail;
        if (cmd == dtq_pkg::CMD_SCHEDULE)
        begin
            if (queued_due.size() >= dtq_pkg::QUEUE_DEPTH)
            begin
                append_result(make_result(dtq_pkg::KIND_REJECTED, '0, 1'b1));
            end
            else
            begin
                due  = clock_ms + dtq_pkg::TIME_BITS'(dly);
                slot = queued_due.size();
                // first entry strictly later than the new deadline; equal ones stay ahead
                for (int i = queued_due.size() - 1; i >= 0; i--)
                begin
                    if (earlier_than(due, queued_due[i]))
                        slot = i;
                end
                queued_due.insert(slot, due);
                queued_tag.insert(slot, tag);
                append_result(make_result(dtq_pkg::KIND_ACCEPTED, tag, 1'b1));
            end
        end
        else
        begin
            clock_ms = clock_ms + 1'b1;
            fired = 0;
            while (queued_due.size() > 0 && earlier_than(queued_due[0], clock_ms))
            begin
                head_tag = queued_tag.pop_front();
                void'(queued_due.pop_front());
                append_result(make_result(dtq_pkg::KIND_FIRED, head_tag, 1'b0));
                fired++;
            end
            if (fired == 0)
            begin
                append_result(make_result(dtq_pkg::KIND_IDLE, '0, 1'b1));
            end
            else
            begin
                tail = awaited_results.pop_back();
                tail.last = 1'b1;
                append_result(tail);
            end
        end
    endtask

    // valid stays high across back-to-back transfers inside a burst
    task automatic send_item(input logic cmd, input logic [dtq_pkg::TAG_BITS-1:0] tag,
                             input logic [dtq_pkg::DELAY_BITS-1:0] dly);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        req_ch.valid   <= 1'b1;
        req_ch.command <= cmd;
        req_ch.job_tag <= tag;
        req_ch.delay   <= dly;
        do
            @(posedge clk);
        while (!req_ch.ready);
        burst_left--;
        schedule_or_tick(cmd, tag, dly);
    endtask

    task automatic send_tick();
        send_item(dtq_pkg::CMD_TICK, dtq_pkg::TAG_BITS'($urandom),
                  dtq_pkg::DELAY_BITS'($urandom));
    endtask

    task automatic send_random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            send_tick();
        else if (pick < 45)
            send_item(dtq_pkg::CMD_SCHEDULE, dtq_pkg::TAG_BITS'($urandom),
                      dtq_pkg::DELAY_BITS'($urandom));
        else
            send_item(dtq_pkg::CMD_SCHEDULE, dtq_pkg::TAG_BITS'($urandom),
                      dtq_pkg::DELAY_BITS'($urandom_range(0, 6)));
    endtask

    task automatic test_empty_tick();
        send_tick();
    endtask

    // fill with equal deadlines, overflow once, then one tick fires every job in order
    task automatic test_fill_and_flush();
        for (int i = 0; i < dtq_pkg::QUEUE_DEPTH; i++)
            send_item(dtq_pkg::CMD_SCHEDULE, dtq_pkg::TAG_BITS'($urandom), '0);
        send_item(dtq_pkg::CMD_SCHEDULE, 8'h3C, 16'h1234);
        send_tick();
    endtask

    task automatic test_extremes();
        send_item(dtq_pkg::CMD_SCHEDULE, 8'h00, 16'h0000);
        send_item(dtq_pkg::CMD_SCHEDULE, 8'hFF, 16'hFFFF);
        send_item(dtq_pkg::CMD_SCHEDULE, 8'hA5, 16'h0001);
        send_item(dtq_pkg::CMD_SCHEDULE, 8'h5A, 16'h0001);
        send_tick();
        send_tick();
        send_tick();
    endtask

    // receiver holds off while requests keep coming, so the input side backs up
    task automatic test_backpressure();
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < 12; i++)
            send_random_item();
    endtask

    task automatic test_random();
        for (int i = 0; i < RANDOM_ITEMS; i++)
            send_random_item();
    endtask

    initial
    begin
        clock_ms = '0;
        rst_n <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.command <= dtq_pkg::CMD_SCHEDULE;
        req_ch.job_tag <= '0;
        req_ch.delay   <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_tick();
        test_fill_and_flush();
        test_extremes();
        test_backpressure();
        test_random();

        req_ch.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // result receiver: random stall modes plus an occasional long hold-off
    initial
    begin
        int mode;
        int mode_left;
        int hold_left;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (mode == 0)
                rsp_ch.ready <= 1'b1;
            else if (mode == 1)
                rsp_ch.ready <= 1'($urandom_range(0, 1));
            else
                rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge clk)
    begin
        timer_result_t want;
        timer_result_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.kind    = rsp_ch.kind;
            got.tag     = rsp_ch.fired_tag;
            got.pending = rsp_ch.pending;
            got.last    = rsp_ch.last;
            if (awaited_results.size() == 0)
            begin
                $display("%0t: unexpected transfer kind %0d tag %0d pending %0d last %0d",
                         $time, got.kind, got.tag, got.pending, got.last);
                errors++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (got !== want)
                begin
                    $display("%0t: expected kind %0d tag %0d pending %0d last %0d", $time,
                             want.kind, want.tag, want.pending, want.last);
                    $display("%0t:   actual kind %0d tag %0d pending %0d last %0d", $time,
                             got.kind, got.tag, got.pending, got.last);
                    errors++;
                end
            end
        end
    end

    // watchdog: too long without any transfer on either channel
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

endmodule
